// ----- sv/assert_macros.svh -----
// Assertion macros used by the message segmenter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tms_pkg.sv -----
// Types, constants and the control store of the message segmenter.
package tms_pkg;

  typedef logic [15:0] dofs_t;
  typedef logic [1:0]  kind_t;
  typedef logic [5:0]  msg_idx_t;
  typedef logic [6:0]  count_t;
  typedef logic [31:0] word_t;
  typedef logic [10:0] groups_t;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] upc_t;
  typedef logic [3:0]      uop_t;
  typedef logic [2:0]      ucond_t;

  typedef struct packed {
    uop_t   op;
    ucond_t cond;
    upc_t   target;
  } ctl_word_t;

  localparam logic [1:0] CFG_EAGER_LIMIT = 2'd0;
  localparam logic [1:0] CFG_NUM_GROUPS  = 2'd1;
  localparam logic [1:0] CFG_NUM_ANGLES  = 2'd2;

  localparam word_t   LIMIT_RESET  = 32'd32768;
  localparam word_t   LIMIT_MIN    = 32'd8;
  localparam groups_t GROUPS_RESET = 11'd1;
  localparam groups_t GROUPS_MAX   = 11'd1024;
  localparam count_t  ANGLES_RESET = 7'd1;
  localparam count_t  ANGLES_MAX   = 7'd64;

  localparam int DIV_LONG_STEPS  = 32;
  localparam int DIV_SHORT_STEPS = 7;

  localparam uop_t OP_WAIT      = 4'd0;
  localparam uop_t OP_MUL1      = 4'd1;
  localparam uop_t OP_MUL2      = 4'd2;
  localparam uop_t OP_PLAN      = 4'd3;
  localparam uop_t OP_NOP       = 4'd4;
  localparam uop_t OP_DIV       = 4'd5;
  localparam uop_t OP_PLAN_Q    = 4'd6;
  localparam uop_t OP_PLAN_SAT  = 4'd7;
  localparam uop_t OP_CHUNK_SET = 4'd8;
  localparam uop_t OP_CHUNK_Q   = 4'd9;
  localparam uop_t OP_CNT_SET   = 4'd10;
  localparam uop_t OP_CNT_Q     = 4'd11;
  localparam uop_t OP_ZERO      = 4'd12;
  localparam uop_t OP_INIT      = 4'd13;
  localparam uop_t OP_EMIT      = 4'd14;

  localparam ucond_t C_NEVER     = 3'd0;
  localparam ucond_t C_ALWAYS    = 3'd1;
  localparam ucond_t C_NO_IN     = 3'd2;
  localparam ucond_t C_FITS      = 3'd3;
  localparam ucond_t C_SAT       = 3'd4;
  localparam ucond_t C_DIV_MORE  = 3'd5;
  localparam ucond_t C_TOT_ZERO  = 3'd6;
  localparam ucond_t C_EMIT_MORE = 3'd7;

  localparam upc_t ST_WAIT   = 5'd0;
  localparam upc_t ST_DIVP   = 5'd5;
  localparam upc_t ST_SAT    = 5'd7;
  localparam upc_t ST_CHUNK  = 5'd8;
  localparam upc_t ST_DIVC   = 5'd9;
  localparam upc_t ST_DIVE   = 5'd12;
  localparam upc_t ST_ZERO   = 5'd14;
  localparam upc_t ST_INIT   = 5'd15;
  localparam upc_t ST_EMIT   = 5'd16;

  function automatic ctl_word_t ucode_rom(input upc_t pc);
    ctl_word_t w;
    case (pc)
      5'd0:    w = '{OP_WAIT,      C_NO_IN,     ST_WAIT};
      5'd1:    w = '{OP_MUL1,      C_NEVER,     ST_WAIT};
      5'd2:    w = '{OP_MUL2,      C_NEVER,     ST_WAIT};
      5'd3:    w = '{OP_PLAN,      C_FITS,      ST_CHUNK};
      5'd4:    w = '{OP_NOP,       C_SAT,       ST_SAT};
      5'd5:    w = '{OP_DIV,       C_DIV_MORE,  ST_DIVP};
      5'd6:    w = '{OP_PLAN_Q,    C_ALWAYS,    ST_CHUNK};
      5'd7:    w = '{OP_PLAN_SAT,  C_NEVER,     ST_WAIT};
      5'd8:    w = '{OP_CHUNK_SET, C_NEVER,     ST_WAIT};
      5'd9:    w = '{OP_DIV,       C_DIV_MORE,  ST_DIVC};
      5'd10:   w = '{OP_CHUNK_Q,   C_TOT_ZERO,  ST_ZERO};
      5'd11:   w = '{OP_CNT_SET,   C_NEVER,     ST_WAIT};
      5'd12:   w = '{OP_DIV,       C_DIV_MORE,  ST_DIVE};
      5'd13:   w = '{OP_CNT_Q,     C_ALWAYS,    ST_INIT};
      5'd14:   w = '{OP_ZERO,      C_NEVER,     ST_WAIT};
      5'd15:   w = '{OP_INIT,      C_NEVER,     ST_WAIT};
      5'd16:   w = '{OP_EMIT,      C_EMIT_MORE, ST_EMIT};
      default: w = '{OP_NOP,       C_ALWAYS,    ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/tms_in_if.sv -----
// Input channel carrying one face entry per transaction.
interface tms_in_if import tms_pkg::*; ();
  logic  valid;
  logic  ready;
  dofs_t face_unknown_count;
  kind_t list_kind;
  logic  restart;

  modport source(output valid, output face_unknown_count, output list_kind,
                 output restart, input ready);
  modport sink(input valid, input face_unknown_count, input list_kind,
               input restart, output ready);
endinterface

// ----- sv/tms_out_if.sv -----
// Result channel carrying one message descriptor per transaction.
interface tms_out_if import tms_pkg::*; ();
  logic     valid;
  logic     ready;
  kind_t    kind_out;
  msg_idx_t message_index;
  word_t    block_position;
  word_t    msg_size;
  count_t   msg_count;
  logic     last_message;
  count_t   running_max_count;

  modport source(output valid, output kind_out, output message_index,
                 output block_position, output msg_size, output msg_count,
                 output last_message, output running_max_count, input ready);
  modport sink(input valid, input kind_out, input message_index,
               input block_position, input msg_size, input msg_count,
               input last_message, input running_max_count, output ready);
endinterface

// ----- sv/transfer_message_segmenter.sv -----
// Top level of the message segmenter: control store sequencer and datapath.
`include "assert_macros.svh"

// Splits each face entry into messages planned against the eager limit. One
// entry is worked on at a time. After an entry is accepted, two multiplications
// form its total; the planned count is then taken from the angles when the entry
// fits the limit, else saturated or divided out, and the chunk size is divided
// out. A non-empty entry has its messages counted by a further division, an empty
// one gets a single message; then the first message is loaded into the output
// register. The shared bit-serial divider produces one quotient bit per cycle.
// Messages then leave at one per cycle while the result side takes them, and the
// block then returns to wait for the next entry. The running maximum is cleared
// by the restart flag of an entry before that entry counts.
module transfer_message_segmenter import tms_pkg::*; #(
  parameter int MAX_MESSAGES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  tms_in_if.sink       in_ch,
  tms_out_if.source    out_ch
);

  localparam count_t MaxMsg = 7'(MAX_MESSAGES);

  word_t     limit_cfg_r;
  groups_t   groups_cfg_r;
  count_t    angles_cfg_r;

  upc_t      pc_r, pc_nxt;
  ctl_word_t cw;

  dofs_t     dofs_r, dofs_nxt;
  kind_t     kind_r, kind_nxt;
  logic [26:0] prod_r, prod_nxt;
  word_t     total_r, total_nxt;
  count_t    planned_r, planned_nxt;
  word_t     chunk_r, chunk_nxt;
  count_t    emitted_r, emitted_nxt;
  count_t    maxc_r, maxc_nxt;
  word_t     rem_r, rem_nxt;
  word_t     pos_r, pos_nxt;
  msg_idx_t  idx_r, idx_nxt;
  word_t     pr_r, pr_nxt;
  word_t     nq_r, nq_nxt;
  word_t     dvs_r, dvs_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  logic      out_valid_r, out_valid_nxt;
  kind_t     out_kind_r, out_kind_nxt;
  msg_idx_t  out_idx_r, out_idx_nxt;
  word_t     out_pos_r, out_pos_nxt;
  word_t     out_size_r, out_size_nxt;
  count_t    out_cnt_r, out_cnt_nxt;
  logic      out_last_r, out_last_nxt;
  count_t    out_max_r, out_max_nxt;

  groups_t   grps;
  count_t    angs;
  word_t     limit;
  logic [34:0] t8;
  logic      fits;
  logic [35:0] plan_num;
  word_t     chunk_num;
  logic [35:0] cnt_num;
  logic [33:0] mul2_full;
  logic [32:0] div_sh;
  logic [32:0] div_diff;
  logic      div_ge;
  count_t    angs_cap;
  count_t    q_cap;
  logic      emit_last;
  word_t     emit_size;
  logic      out_load;
  logic      in_acc;
  logic      cond_true;

  assign cw = ucode_rom(pc_r);
  assign in_ch.ready = (cw.op == OP_WAIT);
  assign in_acc = in_ch.valid && (cw.op == OP_WAIT);

  always_comb begin
    if (groups_cfg_r == 11'd0) begin
      grps = 11'd1;
    end else if (groups_cfg_r > GROUPS_MAX) begin
      grps = GROUPS_MAX;
    end else begin
      grps = groups_cfg_r;
    end
    if (angles_cfg_r == 7'd0) begin
      angs = 7'd1;
    end else if (angles_cfg_r > ANGLES_MAX) begin
      angs = ANGLES_MAX;
    end else begin
      angs = angles_cfg_r;
    end
    limit = (limit_cfg_r < LIMIT_MIN) ? LIMIT_MIN : limit_cfg_r;
  end

  assign t8        = {total_r, 3'b000};
  assign fits      = (t8 <= {3'b000, limit});
  assign plan_num  = {1'b0, t8} + {4'b0000, limit} - 36'd1;
  assign chunk_num = total_r + {25'd0, planned_r} - 32'd1;
  assign cnt_num   = {4'b0000, total_r} + {4'b0000, chunk_r} - 36'd1;
  assign mul2_full = {7'd0, prod_r} * {27'd0, angs};
  assign div_sh    = {pr_r, nq_r[31]};
  assign div_ge    = (div_sh >= {1'b0, dvs_r});
  assign div_diff  = div_sh - {1'b0, dvs_r};
  assign angs_cap  = (angs > MaxMsg) ? MaxMsg : angs;
  assign q_cap     = (nq_r[6:0] > MaxMsg) ? MaxMsg : nq_r[6:0];
  assign emit_last = (({1'b0, idx_r} + 7'd1) == emitted_r);
  assign emit_size = (emit_last || (rem_r < chunk_r)) ? rem_r : chunk_r;
  assign out_load  = !out_valid_r || out_ch.ready;

  always_comb begin
    case (cw.cond)
      C_NEVER:     cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_NO_IN:     cond_true = !in_ch.valid;
      C_FITS:      cond_true = fits;
      C_SAT:       cond_true = (pr_r >= dvs_r);
      C_DIV_MORE:  cond_true = (cnt_r != 6'd1);
      C_TOT_ZERO:  cond_true = (total_r == 32'd0);
      C_EMIT_MORE: cond_true = !(out_load && emit_last);
      default:     cond_true = 1'b0;
    endcase
    pc_nxt = cond_true ? cw.target : pc_r + 5'd1;
  end

  always_comb begin
    dofs_nxt      = dofs_r;
    kind_nxt      = kind_r;
    prod_nxt      = prod_r;
    total_nxt     = total_r;
    planned_nxt   = planned_r;
    chunk_nxt     = chunk_r;
    emitted_nxt   = emitted_r;
    maxc_nxt      = maxc_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    pr_nxt        = pr_r;
    nq_nxt        = nq_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_idx_nxt   = out_idx_r;
    out_pos_nxt   = out_pos_r;
    out_size_nxt  = out_size_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    out_max_nxt   = out_max_r;
    case (cw.op)
      OP_WAIT: begin
        if (in_acc) begin
          dofs_nxt = in_ch.face_unknown_count;
          kind_nxt = in_ch.list_kind;
          if (in_ch.restart) begin
            maxc_nxt = 7'd0;
          end
        end
      end
      OP_MUL1: begin
        prod_nxt = {11'd0, dofs_r} * {16'd0, grps};
      end
      OP_MUL2: begin
        total_nxt = mul2_full[31:0];
      end
      OP_PLAN: begin
        planned_nxt = angs_cap;
        pr_nxt      = {3'b000, plan_num[35:7]};
        nq_nxt      = {plan_num[6:0], 25'd0};
        dvs_nxt     = limit;
        cnt_nxt     = 6'(DIV_SHORT_STEPS);
      end
      OP_DIV: begin
        pr_nxt  = div_ge ? div_diff[31:0] : div_sh[31:0];
        nq_nxt  = {nq_r[30:0], div_ge};
        cnt_nxt = cnt_r - 6'd1;
      end
      OP_PLAN_Q: begin
        planned_nxt = q_cap;
      end
      OP_PLAN_SAT: begin
        planned_nxt = MaxMsg;
      end
      OP_CHUNK_SET: begin
        pr_nxt  = 32'd0;
        nq_nxt  = chunk_num;
        dvs_nxt = {25'd0, planned_r};
        cnt_nxt = 6'(DIV_LONG_STEPS);
      end
      OP_CHUNK_Q: begin
        chunk_nxt = nq_r;
      end
      OP_CNT_SET: begin
        pr_nxt  = {3'b000, cnt_num[35:7]};
        nq_nxt  = {cnt_num[6:0], 25'd0};
        dvs_nxt = chunk_r;
        cnt_nxt = 6'(DIV_SHORT_STEPS);
      end
      OP_CNT_Q: begin
        emitted_nxt = (nq_r[6:0] > planned_r) ? planned_r : nq_r[6:0];
      end
      OP_ZERO: begin
        emitted_nxt = 7'd1;
      end
      OP_INIT: begin
        maxc_nxt = (emitted_r > maxc_r) ? emitted_r : maxc_r;
        rem_nxt  = total_r;
        pos_nxt  = 32'd0;
        idx_nxt  = 6'd0;
      end
      OP_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_idx_nxt   = idx_r;
          out_pos_nxt   = pos_r;
          out_size_nxt  = emit_size;
          out_cnt_nxt   = emitted_r;
          out_last_nxt  = emit_last;
          out_max_nxt   = maxc_r;
          rem_nxt       = rem_r - emit_size;
          pos_nxt       = pos_r + emit_size;
          idx_nxt       = idx_r + 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= ST_WAIT;
      out_valid_r  <= 1'b0;
      limit_cfg_r  <= LIMIT_RESET;
      groups_cfg_r <= GROUPS_RESET;
      angles_cfg_r <= ANGLES_RESET;
      maxc_r       <= 7'd0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      maxc_r      <= maxc_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_EAGER_LIMIT: limit_cfg_r  <= cfg_wdata;
          CFG_NUM_GROUPS:  groups_cfg_r <= cfg_wdata[10:0];
          CFG_NUM_ANGLES:  angles_cfg_r <= cfg_wdata[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    dofs_r     <= dofs_nxt;
    kind_r     <= kind_nxt;
    prod_r     <= prod_nxt;
    total_r    <= total_nxt;
    planned_r  <= planned_nxt;
    chunk_r    <= chunk_nxt;
    emitted_r  <= emitted_nxt;
    rem_r      <= rem_nxt;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    pr_r       <= pr_nxt;
    nq_r       <= nq_nxt;
    dvs_r      <= dvs_nxt;
    cnt_r      <= cnt_nxt;
    out_kind_r <= out_kind_nxt;
    out_idx_r  <= out_idx_nxt;
    out_pos_r  <= out_pos_nxt;
    out_size_r <= out_size_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
    out_max_r  <= out_max_nxt;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.kind_out          = out_kind_r;
  assign out_ch.message_index     = out_idx_r;
  assign out_ch.block_position    = out_pos_r;
  assign out_ch.msg_size          = out_size_r;
  assign out_ch.msg_count         = out_cnt_r;
  assign out_ch.last_message      = out_last_r;
  assign out_ch.running_max_count = out_max_r;

  `TMS_ASSERT_IMP(a_last_index, out_valid_r && out_last_r, ({1'b0, out_idx_r} + 7'd1) == out_cnt_r, "bad last index")
  `TMS_ASSERT_IMP(a_count_range, out_valid_r, (out_cnt_r != 7'd0) && (out_cnt_r <= MaxMsg), "bad count")
  `TMS_ASSERT_IMP(a_max_covers, out_valid_r, out_max_r >= out_cnt_r, "running maximum below count")
  `TMS_ASSERT_IMP(a_inner_nonempty, out_valid_r && !out_last_r, out_size_r != 32'd0, "empty inner message")
  `TMS_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ch.ready, "entry taken while busy")

endmodule
